/* src/vrcm_pkg.sv */
// Package for the valid range coalescing map unit.
// Field widths, operation and status codes, and the command and status
// structs that join the controller and the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vrcm_pkg;

	localparam int OFF_W     = 32;
	localparam int END_W     = 33;
	localparam int LEN_W     = 32;
	localparam int ENTRY_W   = OFF_W + END_W;
	localparam int IDX_W     = 5;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int CNT_OUT_W = 6;

	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic load;
		logic clear;
		logic scan;
		logic eval;
		logic shift;
		logic rd_iss;
		logic rd_cap;
		logic mwr;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic shift_done;
		logic full;
		logic idx_ok;
	} stat_t;

endpackage
`default_nettype wire

/* src/vrcm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module vrcm_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* src/vrcm_dp.sv */
// Datapath of the valid range coalescing map: range store, scan counters,
// merge registers and result registers. Depends on vrcm_pkg and vrcm_ram.
`timescale 1ns / 1ps
`default_nettype none
module vrcm_dp
	import vrcm_pkg::*;
#(
	parameter int MAX_RANGES = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output stat_t                     st,
	input  wire logic [OFF_W-1:0]     in_offset,
	input  wire logic [LEN_W-1:0]     in_length,
	input  wire logic [IDX_W-1:0]     in_index,
	output logic      [STATUS_W-1:0]  out_status,
	output logic      [CNT_OUT_W-1:0] out_count,
	output logic      [OFF_W-1:0]     out_offset,
	output logic      [LEN_W-1:0]     out_length
);

	localparam int AW   = $clog2(MAX_RANGES);
	localparam int CW   = $clog2(MAX_RANGES + 1);
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       pos_q;
	logic [CW-1:0]       m_q;
	logic                dir_q;
	logic                pend_s1;
	logic [AW-1:0]       rdaddr_s1;
	logic [OFF_W-1:0]    off_q;
	logic [END_W-1:0]    end_q;
	logic [IDX_W-1:0]    idx_q;
	logic [OFF_W-1:0]    mst_q;
	logic [END_W-1:0]    men_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [OFF_W-1:0]    res_off_q;
	logic [LEN_W-1:0]    res_len_q;

	logic [ENTRY_W-1:0]  ram_rdata;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [AW-1:0]       ram_waddr;
	logic                ram_we;

	logic [OFF_W-1:0]    rs;
	logic [END_W-1:0]    re;
	logic                issue;
	logic [CW-1:0]       ptr_m1;
	logic [CW:0]         newn;
	logic [CMPW-1:0]     idx_w;
	logic [CW-1:0]       up_addr;
	logic [CW-1:0]       dn_addr;
	logic                lt_count;
	logic                gt_pos;
	logic                e_lt_off;
	logic                touch;

	function automatic logic [LEN_W-1:0] sat_len(input logic [END_W-1:0] diff);
		return diff[END_W-1] ? {LEN_W{1'b1}} : diff[LEN_W-1:0];
	endfunction

	assign rs = ram_rdata[OFF_W-1:0];
	assign re = ram_rdata[ENTRY_W-1:OFF_W];

	assign ptr_m1   = ptr_q - CW'(1);
	assign lt_count = ptr_q < count_q;
	assign gt_pos   = ptr_q > pos_q;
	assign newn     = {1'b0, count_q} - {1'b0, m_q} + (CW+1)'(1);
	assign idx_w    = CMPW'(idx_q);
	assign up_addr  = CW'(rdaddr_s1) + CW'(1);
	assign dn_addr  = CW'(rdaddr_s1) - m_q + CW'(1);

	// An entry touches the new range when the closed intervals meet.
	assign e_lt_off = re < {1'b0, off_q};
	assign touch    = ({1'b0, rs} <= end_q) && (re >= {1'b0, off_q});

	always_comb begin
		issue     = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		if (cmd.scan) begin
			issue = lt_count;
		end else if (cmd.shift && dir_q) begin
			issue     = gt_pos;
			ram_raddr = ptr_m1[AW-1:0];
		end else if (cmd.shift) begin
			issue = lt_count;
		end else if (cmd.rd_iss) begin
			ram_raddr = idx_w[AW-1:0];
		end
	end

	always_comb begin
		ram_we    = cmd.mwr || (cmd.shift && pend_s1);
		ram_waddr = cmd.mwr ? pos_q[AW-1:0] : (dir_q ? up_addr[AW-1:0] : dn_addr[AW-1:0]);
		ram_wdata = cmd.mwr ? {men_q, mst_q} : ram_rdata;
	end

	assign st.scan_done  = !lt_count && !pend_s1;
	assign st.shift_done = (dir_q ? !gt_pos : !lt_count) && !pend_s1;
	assign st.full       = newn > (CW+1)'(MAX_RANGES);
	assign st.idx_ok     = idx_w < CMPW'(count_q);

	vrcm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_RANGES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.mwr) begin
				count_q <= newn[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdaddr_s1 <= ram_raddr;
			ptr_q     <= (cmd.shift && dir_q) ? ptr_m1 : ptr_q + CW'(1);
		end
		if (cmd.load) begin
			off_q        <= in_offset;
			end_q        <= {1'b0, in_offset} + {1'b0, in_length};
			idx_q        <= in_index;
			mst_q        <= in_offset;
			men_q        <= {1'b0, in_offset} + {1'b0, in_length};
			ptr_q        <= '0;
			pos_q        <= '0;
			m_q          <= '0;
			res_status_q <= ST_OK;
			res_off_q    <= '0;
			res_len_q    <= '0;
		end
		if (cmd.scan && pend_s1) begin
			if (e_lt_off) begin
				pos_q <= pos_q + CW'(1);
			end
			if (touch) begin
				m_q <= m_q + CW'(1);
				if (rs < mst_q) begin
					mst_q <= rs;
				end
				if (re > men_q) begin
					men_q <= re;
				end
			end
		end
		if (cmd.eval) begin
			if (st.full) begin
				res_status_q <= ST_FULL;
			end
			// With no merge the tail moves up one slot, walking downward.
			dir_q <= (m_q == '0);
			ptr_q <= (m_q == '0) ? count_q : pos_q + m_q;
		end
		if (cmd.rd_iss && !st.idx_ok) begin
			res_status_q <= ST_RANGE;
		end
		if (cmd.rd_cap) begin
			res_off_q <= rs;
			res_len_q <= (re < {1'b0, rs}) ? '0 : sat_len(re - {1'b0, rs});
		end
		if (cmd.mwr) begin
			res_off_q <= mst_q;
			res_len_q <= sat_len(men_q - {1'b0, mst_q});
		end
		if (cmd.emit) begin
			out_status <= res_status_q;
			out_count  <= CNT_OUT_W'(count_q);
			out_offset <= res_off_q;
			out_length <= res_len_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_RANGES))
		else $error("range count exceeds capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift && ram_we |-> ram_waddr != pos_q[AW-1:0])
		else $error("shift overwrote the merged slot");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.mwr |-> !pend_s1)
		else $error("merged write with a read still in flight");

endmodule
`default_nettype wire

/* src/vrcm_ctrl.sv */
// Controller state machine of the valid range coalescing map.
// Sequences scan, shift, merge write and read; owns the output valid.
// Depends on vrcm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vrcm_ctrl
	import vrcm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [MODE_W-1:0] in_mode,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	input  wire stat_t             st,
	output cmd_t                   cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_MWR   = 3'd4;
	localparam logic [2:0] S_RDISS = 3'd5;
	localparam logic [2:0] S_RDCAP = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (in_mode == MODE_ADD) begin
						state_d = S_SCAN;
					end else if (in_mode == MODE_READ) begin
						state_d = S_RDISS;
					end else begin
						cmd.clear = (in_mode == MODE_CLEAR);
						state_d   = S_DONE;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = st.full ? S_DONE : S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (st.shift_done) begin
					state_d = S_MWR;
				end
			end
			S_MWR: begin
				cmd.mwr = 1'b1;
				state_d = S_DONE;
			end
			S_RDISS: begin
				cmd.rd_iss = 1'b1;
				state_d    = st.idx_ok ? S_RDCAP : S_DONE;
			end
			S_RDCAP: begin
				cmd.rd_cap = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> !out_valid_q || m_tready)
		else $error("result loaded over one not yet taken");
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> !s_tready)
		else $error("input taken while an item is in progress");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.mwr |-> !st.full)
		else $error("merged write for a rejected add");

endmodule
`default_nettype wire

/* src/valid_range_coalescing_map_unit.sv */
// Top level of the valid range coalescing map unit.
// Instantiates vrcm_ctrl and vrcm_dp; depends on vrcm_pkg.
//
// Usage: one item enters on the s_ channel and gives exactly one result on
// the m_ channel. s_tuser carries the mode (add, clear, read); s_tdata
// carries offset, length and entry index. m_tuser carries the status and
// m_tdata the count, offset and length of the entry concerned.
// One item is processed at a time; s_tready is high only while idle.
// An add scans all n held ranges, evaluates, shifts the k entries that move
// (n - p for an insert at slot p, n - p - m when m held entries merge), then
// writes the merged range and emits; a rejected add skips the shift and the
// write. A read issues and then captures the entry, and skips the capture for
// an index at or beyond the count; clear and the unused mode 3 go straight to
// the emit.
// The single read port and single write port of the range store set the add time.
// The result sits in an output register; a new item is accepted while it
// waits, and the next result waits in the controller until it is taken.
// Reset empties the list and drops any pending result; the store itself
// needs no clearing pass since only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none
module valid_range_coalescing_map_unit
	import vrcm_pkg::*;
#(
	parameter int MAX_RANGES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// range_offset[31:0], range_length[63:32], entry_index[68:64], zero pad
	input  wire logic [71:0] s_tdata,
	// mode[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// entry_count[5:0], entry_offset[37:6], entry_length[69:38], zero pad
	output logic      [71:0] m_tdata,
	// status[1:0]
	output logic      [1:0]  m_tuser
);

	cmd_t                 cmd;
	stat_t                st;
	logic [CNT_OUT_W-1:0] out_count;
	logic [OFF_W-1:0]     out_offset;
	logic [LEN_W-1:0]     out_length;

	vrcm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.in_mode (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.st      (st),
		.cmd     (cmd)
	);

	vrcm_dp #(
		.MAX_RANGES(MAX_RANGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_offset (s_tdata[31:0]),
		.in_length (s_tdata[63:32]),
		.in_index  (s_tdata[68:64]),
		.out_status(m_tuser),
		.out_count (out_count),
		.out_offset(out_offset),
		.out_length(out_length)
	);

	assign m_tdata = {2'b00, out_length, out_offset, out_count};

endmodule
`default_nettype wire

/* bench/tb_valid_range_coalescing_map_unit.sv */
// Testbench for valid_range_coalescing_map_unit: a directed table, a fill to
// capacity, then random add, clear, read and unused-mode transfers, checked
// against a behavioral range list. Depends on vrcm_pkg and the unit RTL only.
`timescale 1ns / 1ps
module tb_valid_range_coalescing_map_unit;
	import vrcm_pkg::*;

	localparam int NMAX = 32;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  status;
		logic [5:0]  count;
		logic [31:0] offset;
		logic [31:0] length;
	} result_t;

	typedef struct {
		logic [1:0]  mode;
		logic [31:0] offset;
		logic [31:0] length;
		logic [4:0]  index;
		bit          fixed;
		result_t     want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;

	valid_range_coalescing_map_unit #(.MAX_RANGES(NMAX)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Predicted list contents.
	logic [31:0] list_start [NMAX];
	logic [32:0] list_end [NMAX];
	int          list_count;

	result_t pending_results[$];
	int      errors;
	int      n_sent, n_adds, n_full, n_range, n_checked;
	bit      drain;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb_valid_range_coalescing_map_unit NOT OK");
		$finish;
	end

	function automatic logic [31:0] sat_length(logic [31:0] s, logic [32:0] e);
		logic [32:0] d;
		if (e < {1'b0, s})
			return 32'd0;
		d = e - {1'b0, s};
		return d[32] ? 32'hFFFF_FFFF : d[31:0];
	endfunction

	function automatic bit ranges_touch(logic [31:0] s0, logic [32:0] e0,
		logic [31:0] s1, logic [32:0] e1);
		return (s0 <= s1 && e0 >= {1'b0, s1}) || (s1 <= s0 && e1 >= {1'b0, s0});
	endfunction

	function automatic result_t apply_to_list(logic [1:0] mode, logic [31:0] off,
		logic [31:0] len, logic [4:0] idx);
		logic [31:0] ws [NMAX+1];
		logic [32:0] we [NMAX+1];
		logic [32:0] e;
		int          n, p;
		result_t     r;
		r = '{ST_OK, 6'd0, 32'd0, 32'd0};
		e = {1'b0, off} + {1'b0, len};
		if (mode == MODE_ADD) begin
			n = list_count;
			for (int i = 0; i < n; i++) begin
				ws[i] = list_start[i];
				we[i] = list_end[i];
			end
			// Find the last entry ordered before the new range.
			p = n - 1;
			while (p >= 0 && !(ws[p] < off || (ws[p] == off && we[p] < e)))
				p--;
			if (p >= 0 && ranges_touch(ws[p], we[p], off, e)) begin
				if (off < ws[p]) ws[p] = off;
				if (e > we[p]) we[p] = e;
			end else begin
				p++;
				for (int i = n; i > p; i--) begin
					ws[i] = ws[i-1];
					we[i] = we[i-1];
				end
				ws[p] = off;
				we[p] = e;
				n++;
			end
			while (p + 1 < n && ranges_touch(ws[p], we[p], ws[p+1], we[p+1])) begin
				if (ws[p+1] < ws[p]) ws[p] = ws[p+1];
				if (we[p+1] > we[p]) we[p] = we[p+1];
				for (int i = p + 1; i + 1 < n; i++) begin
					ws[i] = ws[i+1];
					we[i] = we[i+1];
				end
				n--;
			end
			if (n > NMAX) begin
				r.status = ST_FULL;
			end else begin
				for (int i = 0; i < n; i++) begin
					list_start[i] = ws[i];
					list_end[i] = we[i];
				end
				list_count = n;
				r.offset = ws[p];
				r.length = sat_length(ws[p], we[p]);
			end
		end else if (mode == MODE_CLEAR) begin
			list_count = 0;
		end else if (mode == MODE_READ) begin
			if (idx < list_count) begin
				r.offset = list_start[idx];
				r.length = sat_length(list_start[idx], list_end[idx]);
			end else begin
				r.status = ST_RANGE;
			end
		end
		r.count = list_count[5:0];
		return r;
	endfunction

	task automatic send_item(logic [1:0] mode, logic [31:0] off, logic [31:0] len,
		logic [4:0] idx, bit fixed, result_t want);
		result_t r;
		if (!drain && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {3'd0, idx, len, off};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = apply_to_list(mode, off, len, idx);
		if (fixed && (r.status != want.status || r.count != want.count ||
			r.offset != want.offset || r.length != want.length)) begin
			$error("directed row %0d: table value differs from predicted list", n_sent);
			errors++;
		end
		pending_results.push_back(r);
		n_sent++;
		if (mode == MODE_ADD) n_adds++;
		if (r.status == ST_FULL) n_full++;
		if (r.status == ST_RANGE) n_range++;
	endtask

	// Result side: random stalls, compare each transfer with the oldest prediction.
	initial begin
		result_t w;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!drain && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result with no prediction waiting");
					errors++;
				end else begin
					w = pending_results.pop_front();
					n_checked++;
					if (m_tuser != w.status) begin
						$error("status exp %0d got %0d", w.status, m_tuser); errors++;
					end
					if (m_tdata[5:0] != w.count) begin
						$error("entry_count exp %0d got %0d", w.count, m_tdata[5:0]); errors++;
					end
					if (m_tdata[37:6] != w.offset) begin
						$error("entry_offset exp %h got %h", w.offset, m_tdata[37:6]); errors++;
					end
					if (m_tdata[69:38] != w.length) begin
						$error("entry_length exp %h got %h", w.length, m_tdata[69:38]); errors++;
					end
				end
			end
		end
	end

	initial begin
		row_t        rows[$];
		logic [31:0] base, o, l;
		int          k, guard;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = MODE_ADD;
		arst_n   = 1'b0;
		errors = 0; n_sent = 0; n_adds = 0; n_full = 0; n_range = 0; n_checked = 0;
		drain = 0;
		list_count = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{MODE_READ,  32'd0, 32'd0, 5'd0, 1, '{ST_RANGE, 6'd0, 32'd0, 32'd0}},
			'{MODE_ADD,   32'd100, 32'd0, 5'd0, 1, '{ST_OK, 6'd1, 32'd100, 32'd0}},
			'{MODE_ADD,   32'd100, 32'd10, 5'd0, 0, '{ST_OK, 6'd0, 32'd0, 32'd0}},
			'{MODE_ADD,   32'd110, 32'd5, 5'd0, 0, '{ST_OK, 6'd0, 32'd0, 32'd0}},
			'{MODE_ADD,   32'd200, 32'd20, 5'd0, 0, '{ST_OK, 6'd0, 32'd0, 32'd0}},
			'{MODE_ADD,   32'd50, 32'd10, 5'd0, 0, '{ST_OK, 6'd0, 32'd0, 32'd0}},
			'{MODE_ADD,   32'd60, 32'd140, 5'd0, 0, '{ST_OK, 6'd0, 32'd0, 32'd0}},
			'{MODE_READ,  32'd0, 32'd0, 5'd0, 0, '{ST_OK, 6'd0, 32'd0, 32'd0}},
			'{MODE_READ,  32'd0, 32'd0, 5'd31, 1, '{ST_RANGE, 6'd1, 32'd0, 32'd0}},
			'{MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 1,
				'{ST_OK, 6'd1, 32'd0, 32'd0}},
			'{MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 1,
				'{ST_OK, 6'd0, 32'd0, 32'd0}},
			'{MODE_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1,
				'{ST_OK, 6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
			'{MODE_ADD,   32'd0, 32'hFFFF_FFFF, 5'd0, 0, '{ST_OK, 6'd0, 32'd0, 32'd0}},
			'{MODE_READ,  32'd0, 32'd0, 5'd0, 0, '{ST_OK, 6'd0, 32'd0, 32'd0}},
			'{MODE_CLEAR, 32'd0, 32'd0, 5'd0, 1, '{ST_OK, 6'd0, 32'd0, 32'd0}}
		};
		foreach (rows[i])
			send_item(rows[i].mode, rows[i].offset, rows[i].length, rows[i].index,
				rows[i].fixed, rows[i].want);

		// Fill the list to capacity with spaced ranges, then overflow it.
		for (int i = 0; i < NMAX; i++)
			send_item(MODE_ADD, 32'h1000 * i, 32'h10, 5'd0, 0, '{default: '0});
		send_item(MODE_ADD, 32'h8000_0000, 32'd1, 5'd0, 1, '{ST_FULL, 6'd32, 32'd0, 32'd0});
		send_item(MODE_ADD, 32'h1010, 32'd0, 5'd0, 0, '{default: '0});
		send_item(MODE_READ, 32'd0, 32'd0, 5'd31, 0, '{default: '0});

		// Hold the sender until every outstanding result has been checked.
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		base = $urandom;
		for (k = 0; k < 400; k++) begin
			if (k == 340) drain = 1;
			case ($urandom_range(0, 19))
				0: send_item(MODE_CLEAR, $urandom, $urandom, 5'($urandom), 0,
					'{default: '0});
				1: send_item(MODE_UNUSED, $urandom, $urandom, 5'($urandom), 0,
					'{default: '0});
				2, 3, 4, 5: send_item(MODE_READ, $urandom, $urandom, 5'($urandom), 0,
					'{default: '0});
				6: send_item(MODE_ADD, $urandom, $urandom, 5'($urandom), 0,
					'{default: '0});
				default: begin
					// Mostly clustered ranges so that merges and inserts both happen.
					o = base + $urandom_range(0, 4000);
					l = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60);
					if ($urandom_range(0, 30) == 0) base = $urandom;
					send_item(MODE_ADD, o, l, 5'($urandom), 0, '{default: '0});
				end
			endcase
		end
		s_tvalid <= 1'b0;

		guard = 0;
		while (pending_results.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
		$display("Sent %0d transfers (%0d adds), checked %0d results;", n_sent, n_adds,
			n_checked);
		$display("list-full rejects %0d, out-of-range reads %0d.", n_full, n_range);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("tb_valid_range_coalescing_map_unit OK");
		end else begin
			$display("tb_valid_range_coalescing_map_unit NOT OK");
		end
		$finish;
	end
endmodule

/* valid_range_coalescing_map_unit.f */
src/vrcm_pkg.sv
src/vrcm_ram.sv
src/vrcm_dp.sv
src/vrcm_ctrl.sv
src/valid_range_coalescing_map_unit.sv
bench/tb_valid_range_coalescing_map_unit.sv
